/* src/bsp_pkg.sv */
package bsp_pkg;

    // screen and texture geometry
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam int TEX_SIDE      = 64;
    localparam int TEX_CELLS     = TEX_SIDE * TEX_SIDE;

    localparam int COL_W  = 10;                   // column, row and bound fields
    localparam int TEX_AW = $clog2(TEX_SIDE);     // texel coordinate
    localparam int TEX_IW = 12;                   // tex_index field
    localparam int TSZ_W  = 7;                    // tex_width / tex_height

    // arithmetic widths
    localparam int MUL_W = 33;                    // signed multiplier operands
    localparam int ACC_W = 50;                    // det / numx / numy
    localparam int DVD_W = 66;                    // divider dividend and quotient
    localparam int DVS_W = 50;                    // divider divisor

    localparam int PADDR_W = 5;

    // input modes
    localparam logic [1:0] MODE_DEPTH   = 2'd0;
    localparam logic [1:0] MODE_TEXEL   = 2'd1;
    localparam logic [1:0] MODE_PROJECT = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_PLAYER_X   = 3'd0;
    localparam logic [2:0] REG_PLAYER_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X      = 3'd2;
    localparam logic [2:0] REG_DIR_Y      = 3'd3;
    localparam logic [2:0] REG_PLANE_X    = 3'd4;
    localparam logic [2:0] REG_PLANE_Y    = 3'd5;
    localparam logic [2:0] REG_TEX_WIDTH  = 3'd6;
    localparam logic [2:0] REG_TEX_HEIGHT = 3'd7;

    typedef struct packed {
        logic [1:0]        mode;
        logic [COL_W-1:0]  column;
        logic [COL_W-1:0]  row;
        logic [30:0]       depth_value;
        logic [TEX_IW-1:0] tex_index;
        logic [23:0]       texel;
        logic signed [31:0] sprite_x;
        logic signed [31:0] sprite_y;
        logic              quarter_size;
    } in_word_t;

    typedef struct packed {
        logic               draw;
        logic [23:0]        color;
        logic signed [31:0] center_column;
        logic [COL_W-1:0]   first_column;
        logic [COL_W-1:0]   last_column;
        logic [COL_W-1:0]   first_row;
        logic [COL_W-1:0]   last_row;
        logic [15:0]        size_pixels;
        logic               in_front;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] player_x;
        logic signed [31:0] player_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
        logic [TSZ_W-1:0]   tex_width;
        logic [TSZ_W-1:0]   tex_height;
    } cfg_t;

    typedef enum logic [2:0] {
        MS_DET_A, MS_DET_B, MS_NX_A, MS_NX_B, MS_NY_A, MS_NY_B, MS_TX, MS_TY
    } mul_sel_t;

    typedef enum logic [1:0] {
        DS_DEPTH, DS_CENTER, DS_SIZE, DS_TEX
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        mul_sel_t acc_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     fin_depth;
        logic     fin_center;
        logic     fin_size;
        logic     bounds;
        logic     chk;
        logic     fin_tx;
        logic     fin_ty;
        logic     result;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic pass;
    } status_t;

endpackage

/* src/bsp_regs.sv */
module bsp_regs
    import bsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.player_x   <= '0;
            cfg_reg.player_y   <= '0;
            cfg_reg.dir_x      <= 32'sd65536;
            cfg_reg.dir_y      <= '0;
            cfg_reg.plane_x    <= '0;
            cfg_reg.plane_y    <= 32'sd43254;
            cfg_reg.tex_width  <= TSZ_W'(TEX_SIDE);
            cfg_reg.tex_height <= TSZ_W'(TEX_SIDE);
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_PLAYER_X:   cfg_reg.player_x   <= pwdata;
                REG_PLAYER_Y:   cfg_reg.player_y   <= pwdata;
                REG_DIR_X:      cfg_reg.dir_x      <= pwdata;
                REG_DIR_Y:      cfg_reg.dir_y      <= pwdata;
                REG_PLANE_X:    cfg_reg.plane_x    <= pwdata;
                REG_PLANE_Y:    cfg_reg.plane_y    <= pwdata;
                REG_TEX_WIDTH:  cfg_reg.tex_width  <= pwdata[TSZ_W-1:0];
                REG_TEX_HEIGHT: cfg_reg.tex_height <= pwdata[TSZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PLAYER_X:   prdata = cfg_reg.player_x;
            REG_PLAYER_Y:   prdata = cfg_reg.player_y;
            REG_DIR_X:      prdata = cfg_reg.dir_x;
            REG_DIR_Y:      prdata = cfg_reg.dir_y;
            REG_PLANE_X:    prdata = cfg_reg.plane_x;
            REG_PLANE_Y:    prdata = cfg_reg.plane_y;
            REG_TEX_WIDTH:  prdata = 32'(cfg_reg.tex_width);
            REG_TEX_HEIGHT: prdata = 32'(cfg_reg.tex_height);
            default:        prdata = '0;
        endcase
    end

endmodule

/* src/bsp_div.sv */
module bsp_div
    import bsp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a finished run");

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with empty count");

endmodule

/* src/bsp_ctrl.sv */
module bsp_ctrl
    import bsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_mode,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    localparam logic [2:0] MUL_STEPS = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL,
        ST_DEP_GO, ST_DEP_WAIT, ST_CEN_GO, ST_CEN_WAIT, ST_SIZ_GO, ST_SIZ_WAIT,
        ST_BOUNDS,
        ST_QRD, ST_QCHK, ST_TX_MUL, ST_TX_GO, ST_TX_WAIT,
        ST_TY_MUL, ST_TY_GO, ST_TY_WAIT, ST_TEX,
        ST_RESULT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_mode)
                        MODE_PROJECT: begin
                            state_next = ST_MUL;
                            cnt_next   = '0;
                        end
                        MODE_QUERY: state_next = ST_QRD;
                        default:    state_next = ST_RESULT;
                    endcase
                end
            end
            ST_MUL: begin
                if (cnt_reg < MUL_STEPS) begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = mul_sel_t'(cnt_reg);
                end
                if (cnt_reg != '0) begin
                    cmd.acc_en  = 1'b1;
                    cmd.acc_sel = mul_sel_t'(cnt_reg - 3'd1);
                end
                if (cnt_reg == MUL_STEPS) begin
                    state_next = ST_DEP_GO;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_DEP_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_DEPTH;
                state_next    = ST_DEP_WAIT;
            end
            ST_DEP_WAIT: begin
                if (status.div_done) begin
                    cmd.fin_depth = 1'b1;
                    state_next    = ST_CEN_GO;
                end
            end
            ST_CEN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_CENTER;
                state_next    = ST_CEN_WAIT;
            end
            ST_CEN_WAIT: begin
                if (status.div_done) begin
                    cmd.fin_center = 1'b1;
                    state_next     = ST_SIZ_GO;
                end
            end
            ST_SIZ_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_SIZE;
                state_next    = ST_SIZ_WAIT;
            end
            ST_SIZ_WAIT: begin
                if (status.div_done) begin
                    cmd.fin_size = 1'b1;
                    state_next   = ST_BOUNDS;
                end
            end
            ST_BOUNDS: begin
                cmd.bounds = 1'b1;
                state_next = ST_RESULT;
            end
            ST_QRD: state_next = ST_QCHK;
            ST_QCHK: begin
                cmd.chk    = 1'b1;
                state_next = status.pass ? ST_TX_MUL : ST_RESULT;
            end
            ST_TX_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_TX;
                state_next  = ST_TX_GO;
            end
            ST_TX_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_TEX;
                state_next    = ST_TX_WAIT;
            end
            ST_TX_WAIT: begin
                if (status.div_done) begin
                    cmd.fin_tx = 1'b1;
                    state_next = ST_TY_MUL;
                end
            end
            ST_TY_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_TY;
                state_next  = ST_TY_GO;
            end
            ST_TY_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_TEX;
                state_next    = ST_TY_WAIT;
            end
            ST_TY_WAIT: begin
                if (status.div_done) begin
                    cmd.fin_ty = 1'b1;
                    state_next = ST_TEX;
                end
            end
            ST_TEX: state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.result   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* src/bsp_dp.sv */
module bsp_dp
    import bsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  in_word_t  s_data,
    input  cmd_t      cmd,
    output status_t   status,
    output out_word_t m_data
);

    localparam logic [DVD_W-1:0] SIZE_NUM = DVD_W'(SCREEN_HEIGHT) << 16;
    localparam logic signed [33:0] COL_MAX = 34'(SCREEN_WIDTH - 1);
    localparam logic signed [17:0] ROW_MAX = 18'(SCREEN_HEIGHT - 1);
    localparam logic signed [17:0] ROW_MID = 18'(SCREEN_HEIGHT / 2);

    function automatic logic [31:0] sat33(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] sat_quot(input logic [DVD_W-1:0] q, input logic neg);
        if (neg) begin
            if (q > DVD_W'(33'h0_8000_0000)) begin
                return 32'h8000_0000;
            end
            return 32'd0 - q[31:0];
        end
        if (q > DVD_W'(32'h7FFF_FFFF)) begin
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic signed [33:0] v);
        if (v < 34'sd0) begin
            return '0;
        end
        if (v > COL_MAX) begin
            return COL_W'(SCREEN_WIDTH - 1);
        end
        return v[COL_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] clamp_row(input logic signed [17:0] v);
        if (v < 18'sd0) begin
            return '0;
        end
        if (v > ROW_MAX) begin
            return COL_W'(SCREEN_HEIGHT - 1);
        end
        return v[COL_W-1:0];
    endfunction

    function automatic logic [TSZ_W-1:0] eff_size(input logic [TSZ_W-1:0] v);
        if (v == '0) begin
            return TSZ_W'(1);
        end
        if (v > TSZ_W'(TEX_SIDE)) begin
            return TSZ_W'(TEX_SIDE);
        end
        return v;
    endfunction

    // latched item
    logic [1:0]         mode_reg;
    logic [COL_W-1:0]   col_reg, row_reg;
    logic               quarter_reg;
    logic signed [31:0] dx_reg, dy_reg;

    // projection arithmetic
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [2*MUL_W-1:0] pshift;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   det_reg, numx_reg, numy_reg;
    logic signed [ACC_W:0]     nsum;
    logic [ACC_W-1:0]          det_mag, numy_mag;
    logic [ACC_W:0]            nsum_mag;
    logic [31:0]               depth_mag;

    // kept projection
    logic signed [31:0] depth_reg, center_reg;
    logic [15:0]        size_reg;
    logic [COL_W-1:0]   cb0_reg, cb1_reg, rb0_reg, rb1_reg;

    // query
    logic [30:0]        zrd_reg;
    logic [23:0]        tex_rd_reg;
    logic               pass_reg;
    logic [TEX_AW-1:0]  tx_reg, ty_reg;
    logic [TSZ_W-1:0]   tw_eff, th_eff;
    logic signed [34:0] txoff;
    logic [COL_W:0]     tyoff;
    logic               pass;

    logic [14:0]        half;
    logic signed [33:0] cm, cp;
    logic signed [17:0] rm, rp;

    logic [DVD_W-1:0] div_dvd, div_quo;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;

    logic [30:0] depth_mem [SCREEN_WIDTH];
    logic [23:0] texel_mem [TEX_CELLS];

    // magnitudes for the divider
    assign nsum      = {numy_reg[ACC_W-1], numy_reg} + {numx_reg[ACC_W-1], numx_reg};
    assign det_mag   = det_reg[ACC_W-1] ? (ACC_W'(0) - det_reg) : det_reg;
    assign numy_mag  = numy_reg[ACC_W-1] ? (ACC_W'(0) - numy_reg) : numy_reg;
    assign nsum_mag  = nsum[ACC_W] ? ((ACC_W+1)'(0) - nsum) : nsum;
    assign depth_mag = depth_reg[31] ? (32'd0 - depth_reg) : depth_reg;

    assign tw_eff = eff_size(cfg.tex_width);
    assign th_eff = eff_size(cfg.tex_height);
    assign half   = size_reg[15:1];

    assign txoff = 35'(col_reg) - {{3{center_reg[31]}}, center_reg} + 35'(half);
    assign tyoff = {1'b0, row_reg} - {1'b0, rb0_reg};

    always_comb begin
        case (cmd.mul_sel)
            MS_DET_A: begin mul_a = MUL_W'(cfg.plane_x); mul_b = MUL_W'(cfg.dir_y);   end
            MS_DET_B: begin mul_a = MUL_W'(cfg.dir_x);   mul_b = MUL_W'(cfg.plane_y); end
            MS_NX_A:  begin mul_a = MUL_W'(cfg.dir_y);   mul_b = MUL_W'(dx_reg);      end
            MS_NX_B:  begin mul_a = MUL_W'(cfg.dir_x);   mul_b = MUL_W'(dy_reg);      end
            MS_NY_A:  begin mul_a = MUL_W'(cfg.plane_x); mul_b = MUL_W'(dy_reg);      end
            MS_NY_B:  begin mul_a = MUL_W'(cfg.plane_y); mul_b = MUL_W'(dx_reg);      end
            MS_TX: begin
                mul_a = txoff[MUL_W-1:0];
                mul_b = {{(MUL_W-TSZ_W){1'b0}}, tw_eff};
            end
            MS_TY: begin
                mul_a = {{(MUL_W-COL_W-1){1'b0}}, tyoff};
                mul_b = {{(MUL_W-TSZ_W){1'b0}}, th_eff};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Q16.16 products, floored
    assign pshift = prod_reg >>> 16;
    assign term   = pshift[ACC_W-1:0];

    always_comb begin
        case (cmd.div_sel)
            DS_DEPTH:  begin div_dvd = {numy_mag, 16'd0};  div_dvs = det_mag; end
            DS_CENTER: begin
                div_dvd = DVD_W'(nsum_mag) * DVD_W'(SCREEN_WIDTH / 2);
                div_dvs = numy_mag;
            end
            DS_SIZE: begin
                div_dvd = SIZE_NUM;
                div_dvs = quarter_reg ? DVS_W'({depth_mag, 2'b00}) : DVS_W'(depth_mag);
            end
            DS_TEX:  begin div_dvd = $unsigned(prod_reg); div_dvs = DVS_W'(size_reg); end
            default: begin div_dvd = '0; div_dvs = '0; end
        endcase
    end

    bsp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // draw bounds
    assign cm = {{2{center_reg[31]}}, center_reg} - 34'(half);
    assign cp = {{2{center_reg[31]}}, center_reg} + 34'(half);
    assign rm = ROW_MID - 18'(half);
    assign rp = ROW_MID + 18'(half);

    assign pass = ({1'b0, col_reg} < (COL_W+1)'(SCREEN_WIDTH))
               && (depth_reg > 32'sd0)
               && (col_reg >= cb0_reg) && (col_reg < cb1_reg)
               && (row_reg >= rb0_reg) && (row_reg < rb1_reg)
               && (depth_reg[30:0] < zrd_reg);

    assign status.div_done = div_done;
    assign status.pass     = pass;

    // kept projection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= '0;
            center_reg <= '0;
            size_reg   <= '0;
            cb0_reg    <= '0;
            cb1_reg    <= '0;
            rb0_reg    <= '0;
            rb1_reg    <= '0;
        end else begin
            if (cmd.fin_depth) begin
                if (det_reg == '0 || numy_reg == '0) begin
                    depth_reg <= '0;
                end else begin
                    depth_reg <= sat_quot(div_quo, numy_reg[ACC_W-1] ^ det_reg[ACC_W-1]);
                end
            end
            if (cmd.fin_center) begin
                if (numy_reg == '0) begin
                    center_reg <= 32'(SCREEN_WIDTH / 2);
                end else begin
                    center_reg <= sat_quot(div_quo, nsum[ACC_W] ^ numy_reg[ACC_W-1]);
                end
            end
            if (cmd.fin_size) begin
                if (depth_reg == '0 || div_quo > DVD_W'(16'hFFFF)) begin
                    size_reg <= 16'hFFFF;
                end else begin
                    size_reg <= div_quo[15:0];
                end
            end
            if (cmd.bounds) begin
                cb0_reg <= clamp_col(cm);
                cb1_reg <= clamp_col(cp);
                rb0_reg <= clamp_row(rm);
                rb1_reg <= clamp_row(rp);
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg    <= s_data.mode;
            col_reg     <= s_data.column;
            row_reg     <= s_data.row;
            quarter_reg <= s_data.quarter_size;
            dx_reg      <= sat33({s_data.sprite_x[31], s_data.sprite_x}
                                 - {cfg.player_x[31], cfg.player_x});
            dy_reg      <= sat33({s_data.sprite_y[31], s_data.sprite_y}
                                 - {cfg.player_y[31], cfg.player_y});
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_en) begin
            case (cmd.acc_sel)
                MS_DET_A: det_reg  <= term;
                MS_DET_B: det_reg  <= det_reg - term;
                MS_NX_A:  numx_reg <= term;
                MS_NX_B:  numx_reg <= numx_reg - term;
                MS_NY_A:  numy_reg <= term;
                MS_NY_B:  numy_reg <= numy_reg - term;
                default: ;
            endcase
        end
        if (cmd.load) begin
            pass_reg <= 1'b0;
        end else if (cmd.chk) begin
            pass_reg <= pass;
        end
        if (cmd.fin_tx) begin
            if (size_reg == '0) begin
                tx_reg <= '0;
            end else if (div_quo > DVD_W'(tw_eff - TSZ_W'(1))) begin
                tx_reg <= TEX_AW'(tw_eff - TSZ_W'(1));
            end else begin
                tx_reg <= div_quo[TEX_AW-1:0];
            end
        end
        if (cmd.fin_ty) begin
            if (size_reg == '0) begin
                ty_reg <= '0;
            end else if (div_quo > DVD_W'(th_eff - TSZ_W'(1))) begin
                ty_reg <= TEX_AW'(th_eff - TSZ_W'(1));
            end else begin
                ty_reg <= div_quo[TEX_AW-1:0];
            end
        end
    end

    // z-buffer and texture memories
    always_ff @(posedge aclk) begin
        if (cmd.load && s_data.mode == MODE_DEPTH
            && {1'b0, s_data.column} < (COL_W+1)'(SCREEN_WIDTH)) begin
            depth_mem[s_data.column] <= s_data.depth_value;
        end
        zrd_reg <= depth_mem[col_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && s_data.mode == MODE_TEXEL
            && {1'b0, s_data.tex_index} < (TEX_IW+1)'(TEX_CELLS)) begin
            texel_mem[s_data.tex_index] <= s_data.texel;
        end
        tex_rd_reg <= texel_mem[{ty_reg, tx_reg}];
    end

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            m_data.draw          <= (mode_reg == MODE_QUERY) && pass_reg && (tex_rd_reg != '0);
            m_data.color         <= ((mode_reg == MODE_QUERY) && pass_reg) ? tex_rd_reg : '0;
            m_data.center_column <= center_reg;
            m_data.first_column  <= cb0_reg;
            m_data.last_column   <= cb1_reg;
            m_data.first_row     <= rb0_reg;
            m_data.last_row      <= rb1_reg;
            m_data.size_pixels   <= size_reg;
            m_data.in_front      <= (depth_reg > 32'sd0);
        end
    end

endmodule

/* src/billboard_sprite_projector.sv */
// Billboard sprite projector, Q16.16 fixed point.
// s_ channel: one word per operation, selected by s_data.mode (z-buffer column
// load, texel load, sprite projection, pixel query). m_ channel: exactly one
// result word per input word, in order; it always carries the kept projection,
// and draw/color only for a pixel query.
// APB port: camera position, direction, plane and texture size at 4*index;
// write only while the block is idle. pready is tied high.
// Work per word: a load writes its memory; a projection takes 6 shared 33x33
// products, then three runs of the 66-step restoring divider: depth, screen
// column, size; a pixel query does the z-buffer read, two multiply/divide
// passes for the texel coordinates and the texel read, or stops early when the
// pixel fails the bounds or depth test. One word is in flight at a time; the
// divider sets the pace.
// The result sits in an output register: s_ready returns as soon as it is
// loaded, so the next word is taken while m_valid waits on m_ready; a word
// finished while the previous result is still stalled waits for it.
// Reset (aresetn low, synchronous) restores the camera registers and clears
// the kept projection; the z-buffer and texture stay undefined until loaded.
module billboard_sprite_projector
    import bsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    bsp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: walks projection and pixel-query words through the shared multiplier and divider
    bsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, memories, kept projection and the output register
    bsp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule
